FILE: rtl/vgm_command_stream_filter_defines.svh
// ----------------------------------------------------------------------------
// vgm command stream filter assertion macros
// shared property forms used by the filter rtl
// ----------------------------------------------------------------------------
`ifndef VGM_COMMAND_STREAM_FILTER_DEFINES_SVH
`define VGM_COMMAND_STREAM_FILTER_DEFINES_SVH

// condition that must hold at every clock edge out of reset
`define VGMF_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error(msg);

// condition in one cycle implies a consequence in the next
`define VGMF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/vgmf_pkg.sv
// ----------------------------------------------------------------------------
// vgmf_pkg
// types, status codes and command codes of the vgm command stream filter
// ----------------------------------------------------------------------------
package vgmf_pkg;

    localparam int QDEPTH = 4;
    localparam int PTR_W  = $clog2(QDEPTH);
    localparam int CNT_W  = $clog2(QDEPTH + 1);

    // result status codes
    localparam logic [2:0] ST_BYTE    = 3'd0;
    localparam logic [2:0] ST_END     = 3'd1;
    localparam logic [2:0] ST_UNKNOWN = 3'd2;
    localparam logic [2:0] ST_CORRUPT = 3'd3;
    localparam logic [2:0] ST_EARLY   = 3'd4;
    localparam logic [2:0] ST_LIMIT   = 3'd5;

    // command bytes
    localparam logic [7:0] CMD_STEREO     = 8'h4F;
    localparam logic [7:0] CMD_TONE       = 8'h50;
    localparam logic [7:0] CMD_WAIT       = 8'h61;
    localparam logic [7:0] CMD_WAIT_NTSC  = 8'h62;
    localparam logic [7:0] CMD_WAIT_PAL   = 8'h63;
    localparam logic [7:0] CMD_END        = 8'h66;
    localparam logic [7:0] CMD_BLOCK      = 8'h67;
    localparam logic [7:0] CMD_SHORT_LO   = 8'h70;
    localparam logic [7:0] CMD_SHORT_HI   = 8'h7F;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic [2:0]  status;
        logic [15:0] bytes_written;
        logic        last_of_run;
    } result_t;

    // results caused by one accepted word
    typedef struct packed {
        logic [1:0] count;
        result_t    r0;
        result_t    r1;
    } step_out_t;

    function automatic result_t make_result(logic [7:0] b, logic [2:0] st,
                                            logic [15:0] bw, logic last);
        result_t r;
        r.out_byte      = b;
        r.status        = st;
        r.bytes_written = bw;
        r.last_of_run   = last;
        return r;
    endfunction

endpackage

FILE: rtl/vgmf_parser.sv
// ----------------------------------------------------------------------------
// vgmf_parser
// command phase tracking and result generation for one input word per cycle while accept is high
// ----------------------------------------------------------------------------
`include "vgm_command_stream_filter_defines.svh"

module vgmf_parser #(
    parameter int unsigned OUTPUT_LIMIT         = 65532,
    parameter int unsigned DELAY_PRESCALE_SHIFT = 4
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                accept,
    input  logic [7:0]          data_byte,
    input  logic                input_ended,
    output vgmf_pkg::step_out_t step_out
);

    localparam logic [3:0] PH_CMD    = 4'd0;
    localparam logic [3:0] PH_STEREO = 4'd1;
    localparam logic [3:0] PH_TONE   = 4'd2;
    localparam logic [3:0] PH_DLO    = 4'd3;
    localparam logic [3:0] PH_DHI    = 4'd4;
    localparam logic [3:0] PH_BMARK  = 4'd5;
    localparam logic [3:0] PH_BTYPE  = 4'd6;
    localparam logic [3:0] PH_BLEN0  = 4'd7;
    localparam logic [3:0] PH_BLEN1  = 4'd8;
    localparam logic [3:0] PH_BLEN2  = 4'd9;
    localparam logic [3:0] PH_BLEN3  = 4'd10;
    localparam logic [3:0] PH_BBODY  = 4'd11;
    localparam logic [3:0] PH_HALT   = 4'd12;

    localparam logic [15:0] LIMIT = 16'(OUTPUT_LIMIT);

    logic [3:0]  phase_reg, phase_next;
    logic [31:0] blk_reg,   blk_next;
    logic [7:0]  dlo_reg,   dlo_next;
    logic [15:0] bw_reg,    bw_next;
    logic [2:0]  stop_reg,  stop_next;

    logic [15:0] bw_inc1;
    logic [15:0] bw_inc2;
    logic [15:0] wait_scaled;

    assign bw_inc1     = bw_reg + 16'd1;
    assign bw_inc2     = bw_reg + 16'd2;
    assign wait_scaled = {data_byte, dlo_reg} >> DELAY_PRESCALE_SHIFT;

    always_comb begin
        phase_next     = phase_reg;
        blk_next       = blk_reg;
        dlo_next       = dlo_reg;
        bw_next        = bw_reg;
        stop_next      = stop_reg;
        step_out       = '0;

        if (phase_reg == PH_HALT) begin
            step_out.count = 2'd1;
            step_out.r0    = vgmf_pkg::make_result(8'h00, stop_reg, bw_reg, 1'b1);
        end else if (phase_reg == PH_CMD) begin
            if (bw_reg >= LIMIT) begin
                phase_next     = PH_HALT;
                stop_next      = vgmf_pkg::ST_LIMIT;
                step_out.count = 2'd1;
                step_out.r0    = vgmf_pkg::make_result(8'h00, vgmf_pkg::ST_LIMIT,
                                                       bw_reg, 1'b1);
            end else if (input_ended) begin
                phase_next     = PH_HALT;
                stop_next      = vgmf_pkg::ST_EARLY;
                step_out.count = 2'd1;
                step_out.r0    = vgmf_pkg::make_result(8'h00, vgmf_pkg::ST_EARLY,
                                                       bw_reg, 1'b1);
            end else if (data_byte == vgmf_pkg::CMD_STEREO) begin
                phase_next = PH_STEREO;
            end else if (data_byte == vgmf_pkg::CMD_TONE ||
                         data_byte == vgmf_pkg::CMD_WAIT ||
                         data_byte == vgmf_pkg::CMD_WAIT_NTSC ||
                         data_byte == vgmf_pkg::CMD_WAIT_PAL) begin
                bw_next        = bw_inc1;
                step_out.count = 2'd1;
                step_out.r0    = vgmf_pkg::make_result(data_byte, vgmf_pkg::ST_BYTE,
                                                       bw_inc1, 1'b1);
                if (data_byte == vgmf_pkg::CMD_TONE) begin
                    phase_next = PH_TONE;
                end else if (data_byte == vgmf_pkg::CMD_WAIT) begin
                    phase_next = PH_DLO;
                end
            end else if (data_byte == vgmf_pkg::CMD_END) begin
                phase_next     = PH_HALT;
                stop_next      = vgmf_pkg::ST_END;
                step_out.count = 2'd1;
                step_out.r0    = vgmf_pkg::make_result(8'h00, vgmf_pkg::ST_END,
                                                       bw_reg, 1'b1);
            end else if (data_byte == vgmf_pkg::CMD_BLOCK) begin
                phase_next = PH_BMARK;
            end else if (data_byte >= vgmf_pkg::CMD_SHORT_LO &&
                         data_byte <= vgmf_pkg::CMD_SHORT_HI) begin
                // short wait, dropped
                phase_next = PH_CMD;
            end else begin
                phase_next     = PH_HALT;
                stop_next      = vgmf_pkg::ST_UNKNOWN;
                step_out.count = 2'd1;
                step_out.r0    = vgmf_pkg::make_result(8'h00, vgmf_pkg::ST_UNKNOWN,
                                                       bw_reg, 1'b1);
            end
        end else if (input_ended) begin
            phase_next     = PH_HALT;
            stop_next      = vgmf_pkg::ST_EARLY;
            step_out.count = 2'd1;
            step_out.r0    = vgmf_pkg::make_result(8'h00, vgmf_pkg::ST_EARLY,
                                                   bw_reg, 1'b1);
        end else begin
            case (phase_reg)
                PH_STEREO: begin
                    phase_next = PH_CMD;
                end
                PH_TONE: begin
                    bw_next        = bw_inc1;
                    step_out.count = 2'd1;
                    step_out.r0    = vgmf_pkg::make_result(data_byte, vgmf_pkg::ST_BYTE,
                                                           bw_inc1, 1'b1);
                    phase_next     = PH_CMD;
                end
                PH_DLO: begin
                    dlo_next   = data_byte;
                    phase_next = PH_DHI;
                end
                PH_DHI: begin
                    bw_next        = bw_inc2;
                    step_out.count = 2'd2;
                    step_out.r0    = vgmf_pkg::make_result(wait_scaled[7:0],
                                                           vgmf_pkg::ST_BYTE, bw_inc1, 1'b0);
                    step_out.r1    = vgmf_pkg::make_result(wait_scaled[15:8],
                                                           vgmf_pkg::ST_BYTE, bw_inc2, 1'b1);
                    phase_next     = PH_CMD;
                end
                PH_BMARK: begin
                    if (data_byte == vgmf_pkg::CMD_END) begin
                        phase_next = PH_BTYPE;
                    end else begin
                        phase_next     = PH_HALT;
                        stop_next      = vgmf_pkg::ST_CORRUPT;
                        step_out.count = 2'd1;
                        step_out.r0    = vgmf_pkg::make_result(8'h00,
                                                               vgmf_pkg::ST_CORRUPT,
                                                               bw_reg, 1'b1);
                    end
                end
                PH_BTYPE: begin
                    blk_next   = '0;
                    phase_next = PH_BLEN0;
                end
                PH_BLEN0: begin
                    blk_next[7:0] = data_byte;
                    phase_next    = PH_BLEN1;
                end
                PH_BLEN1: begin
                    blk_next[15:8] = data_byte;
                    phase_next     = PH_BLEN2;
                end
                PH_BLEN2: begin
                    blk_next[23:16] = data_byte;
                    phase_next      = PH_BLEN3;
                end
                PH_BLEN3: begin
                    blk_next[31:24] = data_byte;
                    // zero-length block goes straight back to commands
                    phase_next = ({data_byte, blk_reg[23:0]} != 32'd0) ? PH_BBODY : PH_CMD;
                end
                PH_BBODY: begin
                    blk_next = blk_reg - 32'd1;
                    if (blk_reg == 32'd1) begin
                        phase_next = PH_CMD;
                    end
                end
                default: begin
                    phase_next = PH_CMD;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_CMD;
            blk_reg   <= '0;
            bw_reg    <= '0;
            stop_reg  <= vgmf_pkg::ST_BYTE;
        end else if (accept) begin
            phase_reg <= phase_next;
            blk_reg   <= blk_next;
            bw_reg    <= bw_next;
            stop_reg  <= stop_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            dlo_reg <= dlo_next;
        end
    end

    `VGMF_ASSERT_NEXT(a_halt_sticks, phase_reg == PH_HALT, phase_reg == PH_HALT, "parser left halt without reset")
    `VGMF_ASSERT_NEXT(a_bw_step, 1'b1, (16'(bw_reg - $past(bw_reg)) <= 16'd2), "byte count jumped by more than two")
    `VGMF_ASSERT_ALWAYS(a_halt_code, (phase_reg != PH_HALT) || (stop_reg != vgmf_pkg::ST_BYTE), "halted with byte status")

endmodule

FILE: rtl/vgmf_out_queue.sv
// ----------------------------------------------------------------------------
// vgmf_out_queue
// small result queue taking up to two results per cycle and giving one while out_ready is high
// ----------------------------------------------------------------------------
`include "vgm_command_stream_filter_defines.svh"

module vgmf_out_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  vgmf_pkg::step_out_t step_out,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output vgmf_pkg::result_t   out_head
);

    vgmf_pkg::result_t entries_reg [vgmf_pkg::QDEPTH];

    logic [vgmf_pkg::PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [vgmf_pkg::PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [vgmf_pkg::CNT_W-1:0] count_reg,  count_next;
    logic [vgmf_pkg::PTR_W-1:0] wr_ptr_p1;
    logic [1:0]                 n_push;
    logic                       pop;

    // room for a full two-result word must exist before accepting
    assign in_ready  = count_reg <= vgmf_pkg::CNT_W'(vgmf_pkg::QDEPTH - 2);
    assign out_valid = count_reg != '0;
    assign out_head  = entries_reg[rd_ptr_reg];
    assign pop       = out_valid & out_ready;
    assign n_push    = push ? step_out.count : 2'd0;
    assign wr_ptr_p1 = wr_ptr_reg + vgmf_pkg::PTR_W'(1);

    always_comb begin
        wr_ptr_next = wr_ptr_reg + vgmf_pkg::PTR_W'(n_push);
        rd_ptr_next = rd_ptr_reg + vgmf_pkg::PTR_W'(pop);
        count_next  = count_reg + vgmf_pkg::CNT_W'(n_push) - vgmf_pkg::CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (n_push != 2'd0) begin
            entries_reg[wr_ptr_reg] <= step_out.r0;
        end
        if (n_push == 2'd2) begin
            entries_reg[wr_ptr_p1] <= step_out.r1;
        end
    end

    `VGMF_ASSERT_ALWAYS(a_count_bound, count_reg <= vgmf_pkg::CNT_W'(vgmf_pkg::QDEPTH), "result queue overflow")
    `VGMF_ASSERT_ALWAYS(a_push_room, !push || (count_reg <= vgmf_pkg::CNT_W'(vgmf_pkg::QDEPTH - 2)), "push without room")
    `VGMF_ASSERT_NEXT(a_ptr_track, 1'b1, vgmf_pkg::PTR_W'(wr_ptr_reg - rd_ptr_reg) == count_reg[vgmf_pkg::PTR_W-1:0], "pointers disagree with count")

endmodule

FILE: rtl/vgm_command_stream_filter.sv
// output: each result is queued when its byte is accepted and offered in order
// throughput: one byte per cycle while the master side is ready; only the last byte of a
//   0x61 wait gives two results and it always follows a byte that gives none, so the
//   four-entry result queue holds at most two and never stalls the input
// reset: synchronous aresetn low returns the parser to the command phase, clears the
//   byte count and empties the result queue; no clearing pass is needed
// ----------------------------------------------------------------------------
// vgm_command_stream_filter
// compacts a vgm sound-data byte stream to tone writes, waits, stop codes and frame waits
// ----------------------------------------------------------------------------
module vgm_command_stream_filter #(
    parameter int unsigned OUTPUT_LIMIT         = 65532,
    parameter int unsigned DELAY_PRESCALE_SHIFT = 4
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] input_ended

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] out_byte, [23:8] bytes_written
    output logic [2:0]  m_tuser,   // [2:0] status
    output logic        m_tlast    // last_of_run
);

    logic                accept;
    vgmf_pkg::step_out_t step_out;
    vgmf_pkg::result_t   head;

    assign accept = s_tvalid & s_tready;

    vgmf_parser #(
        .OUTPUT_LIMIT         (OUTPUT_LIMIT),
        .DELAY_PRESCALE_SHIFT (DELAY_PRESCALE_SHIFT)
    ) u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (accept),
        .data_byte   (s_tdata),
        .input_ended (s_tuser),
        .step_out    (step_out)
    );

    vgmf_out_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (accept),
        .step_out  (step_out),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_head  (head)
    );

    assign m_tdata = {head.bytes_written, head.out_byte};
    assign m_tuser = head.status;
    assign m_tlast = head.last_of_run;

endmodule

FILE: verif/vgm_command_stream_filter_tb.sv
// ----------------------------------------------------------------------------
// vgm_command_stream_filter_tb
// drives raw vgm sound-data bytes into the filter and checks every output word
// against a cycle-free prediction of the compacted stream, across several
// idling mixes, then stops the parser once by a randomly chosen halt cause
// ----------------------------------------------------------------------------
module vgm_command_stream_filter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned OUTPUT_LIMIT  = 65532;
    localparam int unsigned DELAY_SHIFT   = 4;
    localparam int          QUIET_LIMIT   = 4000;
    localparam int          PHASE_WORDS   = 230;
    localparam int          TAIL_CYCLES   = 16;
    localparam int          REPORT_MAX    = 10;

    typedef enum logic [3:0] {
        P_CMD, P_STEREO_ARG, P_TONE_ARG, P_WAIT_LO, P_WAIT_HI,
        P_BLK_MARK, P_BLK_TYPE, P_LEN0, P_LEN1, P_LEN2, P_LEN3, P_BODY, P_HALTED
    } parse_ph_t;

    typedef enum logic [2:0] {
        STOP_END, STOP_UNKNOWN, STOP_CORRUPT, STOP_EARLY, STOP_LIMIT
    } stop_kind_t;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        s_tuser  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    // idling mix, percent of cycles
    int src_idle_pct  = 0;
    int snk_stall_pct = 0;

    int words_sent = 0;
    int mismatches = 0;

    // predicted parser state
    parse_ph_t   phase     = P_CMD;
    logic [31:0] blk_left  = '0;
    logic [7:0]  delay_lo  = '0;
    logic [15:0] out_count = '0;
    logic [2:0]  stop_code = vgmf_pkg::ST_BYTE;

    vgmf_pkg::result_t expected_words[$];

    vgm_command_stream_filter #(
        .OUTPUT_LIMIT        (OUTPUT_LIMIT),
        .DELAY_PRESCALE_SHIFT(DELAY_SHIFT)
    ) u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    always begin
        aclk = 1'b1;
        #6;
        aclk = 1'b0;
        #6;
    end

    // compute the output words caused by one accepted input word
    task automatic predict_filter(input logic [7:0] b, input logic ended);
        vgmf_pkg::result_t res [2];
        int                n;
        logic              do_halt;
        logic [2:0]        halt_st;
        logic [31:0]       v;
        n       = 0;
        do_halt = 1'b0;
        halt_st = vgmf_pkg::ST_BYTE;
        if (phase == P_HALTED) begin
            res[0] = '{out_byte: 8'h00, status: stop_code, bytes_written: out_count,
                       last_of_run: 1'b0};
            n = 1;
        end else if (phase == P_CMD) begin
            if (out_count >= OUTPUT_LIMIT) begin
                do_halt = 1'b1;
                halt_st = vgmf_pkg::ST_LIMIT;
            end else if (ended) begin
                do_halt = 1'b1;
                halt_st = vgmf_pkg::ST_EARLY;
            end else if (b == vgmf_pkg::CMD_STEREO) begin
                phase = P_STEREO_ARG;
            end else if (b == vgmf_pkg::CMD_TONE || b == vgmf_pkg::CMD_WAIT ||
                         b == vgmf_pkg::CMD_WAIT_NTSC || b == vgmf_pkg::CMD_WAIT_PAL) begin
                out_count = out_count + 16'd1;
                res[0] = '{out_byte: b, status: vgmf_pkg::ST_BYTE,
                           bytes_written: out_count, last_of_run: 1'b0};
                n = 1;
                if (b == vgmf_pkg::CMD_TONE)
                    phase = P_TONE_ARG;
                else if (b == vgmf_pkg::CMD_WAIT)
                    phase = P_WAIT_LO;
            end else if (b == vgmf_pkg::CMD_END) begin
                do_halt = 1'b1;
                halt_st = vgmf_pkg::ST_END;
            end else if (b == vgmf_pkg::CMD_BLOCK) begin
                phase = P_BLK_MARK;
            end else if (!(b >= vgmf_pkg::CMD_SHORT_LO && b <= vgmf_pkg::CMD_SHORT_HI)) begin
                do_halt = 1'b1;
                halt_st = vgmf_pkg::ST_UNKNOWN;
            end
        end else if (ended) begin
            do_halt = 1'b1;
            halt_st = vgmf_pkg::ST_EARLY;
        end else begin
            case (phase)
                P_STEREO_ARG: phase = P_CMD;
                P_TONE_ARG: begin
                    out_count = out_count + 16'd1;
                    res[0] = '{out_byte: b, status: vgmf_pkg::ST_BYTE,
                               bytes_written: out_count, last_of_run: 1'b0};
                    n = 1;
                    phase = P_CMD;
                end
                P_WAIT_LO: begin
                    delay_lo = b;
                    phase    = P_WAIT_HI;
                end
                P_WAIT_HI: begin
                    v = {16'h0000, b, delay_lo} >> DELAY_SHIFT;
                    out_count = out_count + 16'd1;
                    res[0] = '{out_byte: v[7:0], status: vgmf_pkg::ST_BYTE,
                               bytes_written: out_count, last_of_run: 1'b0};
                    out_count = out_count + 16'd1;
                    res[1] = '{out_byte: v[15:8], status: vgmf_pkg::ST_BYTE,
                               bytes_written: out_count, last_of_run: 1'b0};
                    n = 2;
                    phase = P_CMD;
                end
                P_BLK_MARK: begin
                    if (b == vgmf_pkg::CMD_END) begin
                        phase = P_BLK_TYPE;
                    end else begin
                        do_halt = 1'b1;
                        halt_st = vgmf_pkg::ST_CORRUPT;
                    end
                end
                P_BLK_TYPE: begin
                    blk_left = '0;
                    phase    = P_LEN0;
                end
                P_LEN0: begin
                    blk_left[7:0] = b;
                    phase = P_LEN1;
                end
                P_LEN1: begin
                    blk_left[15:8] = b;
                    phase = P_LEN2;
                end
                P_LEN2: begin
                    blk_left[23:16] = b;
                    phase = P_LEN3;
                end
                P_LEN3: begin
                    blk_left[31:24] = b;
                    phase = (blk_left != 0) ? P_BODY : P_CMD;
                end
                P_BODY: begin
                    blk_left = blk_left - 32'd1;
                    if (blk_left == 0)
                        phase = P_CMD;
                end
                default: phase = P_CMD;
            endcase
        end
        if (do_halt) begin
            phase     = P_HALTED;
            stop_code = halt_st;
            res[0] = '{out_byte: 8'h00, status: halt_st, bytes_written: out_count,
                       last_of_run: 1'b0};
            n = 1;
        end
        for (int i = 0; i < n; i++) begin
            res[i].last_of_run = (i == n - 1);
            expected_words.push_back(res[i]);
        end
    endtask

    // offer one word, return at the edge where it is taken
    task automatic send_word(input logic [7:0] b, input logic ended);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= ended;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        predict_filter(b, ended);
        words_sent++;
    endtask

    // hold the sender off until every predicted word has come out
    task automatic wait_drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_words.size() != 0)
            @(posedge aclk);
    endtask

    task automatic send_block(input logic [7:0] kind_byte, input logic [31:0] len);
        send_word(vgmf_pkg::CMD_BLOCK, 1'b0);
        send_word(vgmf_pkg::CMD_END, 1'b0);
        send_word(kind_byte, 1'b0);
        for (int i = 0; i < 4; i++)
            send_word(len[8*i +: 8], 1'b0);
        for (int unsigned i = 0; i < len; i++)
            send_word(8'($urandom_range(255)), 1'b0);
    endtask

    // one complete well-formed command with random content
    task automatic send_random_command();
        int pick;
        pick = $urandom_range(99);
        if (pick < 25) begin
            send_word(vgmf_pkg::CMD_TONE, 1'b0);
            send_word(8'($urandom_range(255)), 1'b0);
        end else if (pick < 45) begin
            send_word(vgmf_pkg::CMD_WAIT, 1'b0);
            send_word(8'($urandom_range(255)), 1'b0);
            send_word(8'($urandom_range(255)), 1'b0);
        end else if (pick < 65) begin
            send_word($urandom_range(1) ? vgmf_pkg::CMD_WAIT_PAL : vgmf_pkg::CMD_WAIT_NTSC,
                      1'b0);
        end else if (pick < 75) begin
            send_word(vgmf_pkg::CMD_STEREO, 1'b0);
            send_word(8'($urandom_range(255)), 1'b0);
        end else if (pick < 87) begin
            send_word(8'($urandom_range(vgmf_pkg::CMD_SHORT_HI, vgmf_pkg::CMD_SHORT_LO)),
                      1'b0);
        end else begin
            send_block(8'($urandom_range(255)), 32'($urandom_range(6)));
        end
    endtask

    task automatic test_directed_commands();
        send_word(vgmf_pkg::CMD_TONE, 1'b0);
        send_word(8'h00, 1'b0);
        send_word(vgmf_pkg::CMD_TONE, 1'b0);
        send_word(8'hFF, 1'b0);
        send_word(vgmf_pkg::CMD_WAIT, 1'b0);
        send_word(8'h00, 1'b0);
        send_word(8'h00, 1'b0);
        send_word(vgmf_pkg::CMD_WAIT, 1'b0);
        send_word(8'hFF, 1'b0);
        send_word(8'hFF, 1'b0);
        send_word(vgmf_pkg::CMD_WAIT, 1'b0);
        send_word(8'h34, 1'b0);
        send_word(8'h12, 1'b0);
        send_word(vgmf_pkg::CMD_WAIT_NTSC, 1'b0);
        send_word(vgmf_pkg::CMD_WAIT_PAL, 1'b0);
        send_word(vgmf_pkg::CMD_STEREO, 1'b0);
        send_word(8'hAA, 1'b0);
        send_word(vgmf_pkg::CMD_SHORT_LO, 1'b0);
        send_word(vgmf_pkg::CMD_SHORT_HI, 1'b0);
    endtask

    task automatic test_data_blocks();
        // zero length goes straight back to the command phase
        send_block(8'h00, 32'd0);
        send_block(8'hFF, 32'd3);
        send_word(vgmf_pkg::CMD_WAIT_NTSC, 1'b0);
        send_block(8'h5A, 32'h0000_0101);
        send_word(vgmf_pkg::CMD_TONE, 1'b0);
        send_word(8'h81, 1'b0);
    endtask

    task automatic test_random_traffic();
        int start;
        for (int mode = 0; mode < 4; mode++) begin
            case (mode)
                0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
                1: begin src_idle_pct = 55; snk_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  snk_stall_pct = 55; end
                default: begin src_idle_pct = 38; snk_stall_pct = 38; end
            endcase
            start = words_sent;
            while (words_sent - start < PHASE_WORDS) begin
                send_random_command();
                if (mode == 2 && words_sent - start >= PHASE_WORDS / 2 &&
                    words_sent - start < PHASE_WORDS / 2 + 4)
                    wait_drain();
            end
        end
    endtask

    task automatic test_halt(input stop_kind_t kind);
        logic [7:0] b;
        int         depth;
        case (kind)
            STOP_END: send_word(vgmf_pkg::CMD_END, 1'b0);
            STOP_UNKNOWN: begin
                do b = 8'($urandom_range(255));
                while (b == vgmf_pkg::CMD_STEREO || b == vgmf_pkg::CMD_TONE ||
                       b == vgmf_pkg::CMD_WAIT || b == vgmf_pkg::CMD_WAIT_NTSC ||
                       b == vgmf_pkg::CMD_WAIT_PAL || b == vgmf_pkg::CMD_END ||
                       b == vgmf_pkg::CMD_BLOCK ||
                       (b >= vgmf_pkg::CMD_SHORT_LO && b <= vgmf_pkg::CMD_SHORT_HI));
                send_word(b, 1'b0);
            end
            STOP_CORRUPT: begin
                do b = 8'($urandom_range(255));
                while (b == vgmf_pkg::CMD_END);
                send_word(vgmf_pkg::CMD_BLOCK, 1'b0);
                send_word(b, 1'b0);
            end
            STOP_EARLY: begin
                // cut the stream off at a random point inside a command or between commands
                case ($urandom_range(8))
                    0: ;
                    1: send_word(vgmf_pkg::CMD_STEREO, 1'b0);
                    2: send_word(vgmf_pkg::CMD_TONE, 1'b0);
                    3: send_word(vgmf_pkg::CMD_WAIT, 1'b0);
                    4: begin
                        send_word(vgmf_pkg::CMD_WAIT, 1'b0);
                        send_word(8'($urandom_range(255)), 1'b0);
                    end
                    5: send_word(vgmf_pkg::CMD_BLOCK, 1'b0);
                    6: begin
                        send_word(vgmf_pkg::CMD_BLOCK, 1'b0);
                        send_word(vgmf_pkg::CMD_END, 1'b0);
                    end
                    7: begin
                        send_word(vgmf_pkg::CMD_BLOCK, 1'b0);
                        send_word(vgmf_pkg::CMD_END, 1'b0);
                        send_word(8'($urandom_range(255)), 1'b0);
                        depth = $urandom_range(3);
                        for (int i = 0; i < depth; i++)
                            send_word(8'($urandom_range(255)), 1'b0);
                    end
                    default: begin
                        send_word(vgmf_pkg::CMD_BLOCK, 1'b0);
                        send_word(vgmf_pkg::CMD_END, 1'b0);
                        send_word(8'($urandom_range(255)), 1'b0);
                        send_word(8'd5, 1'b0);
                        for (int i = 0; i < 3; i++)
                            send_word(8'h00, 1'b0);
                        depth = $urandom_range(4);
                        for (int i = 0; i < depth; i++)
                            send_word(8'($urandom_range(255)), 1'b0);
                    end
                endcase
                send_word(8'($urandom_range(255)), 1'b1);
            end
            default: begin
                // run the count up to the limit at full rate
                src_idle_pct  = 0;
                snk_stall_pct = 0;
                while (out_count < OUTPUT_LIMIT)
                    send_random_command();
                send_word(8'($urandom_range(255)), 1'($urandom_range(1)));
            end
        endcase
    endtask

    task automatic test_after_halt();
        src_idle_pct  = 38;
        snk_stall_pct = 38;
        for (int i = 0; i < 24; i++)
            send_word(8'($urandom_range(255)), 1'($urandom_range(1)));
    endtask

    // output side: random back-pressure and word check
    always @(posedge aclk) begin
        vgmf_pkg::result_t got;
        vgmf_pkg::result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = '{out_byte: m_tdata[7:0], status: m_tuser,
                    bytes_written: m_tdata[23:8], last_of_run: m_tlast};
            if (expected_words.size() == 0) begin
                if (mismatches < REPORT_MAX)
                    $display("unexpected word: byte %h status %0d count %0d last %b",
                             got.out_byte, got.status, got.bytes_written, got.last_of_run);
                mismatches++;
            end else begin
                want = expected_words.pop_front();
                if (got != want) begin
                    if (mismatches < REPORT_MAX)
                        $display({"mismatch: expected byte %h status %0d count %0d last %b,",
                                  " got byte %h status %0d count %0d last %b"},
                                 want.out_byte, want.status, want.bytes_written,
                                 want.last_of_run, got.out_byte, got.status,
                                 got.bytes_written, got.last_of_run);
                    mismatches++;
                end
            end
        end
        m_tready <= ($urandom_range(99) >= snk_stall_pct);
    end

    // watchdog on cycles with no handshake on either side
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed_commands();
        test_data_blocks();
        test_random_traffic();
        wait_drain();
        // the output count limit lies far beyond this stream length
        test_halt(stop_kind_t'($urandom_range(3)));
        test_after_halt();
        wait_drain();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatches == 0 && expected_words.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+rtl
rtl/vgmf_pkg.sv
rtl/vgmf_parser.sv
rtl/vgmf_out_queue.sv
rtl/vgm_command_stream_filter.sv
verif/vgm_command_stream_filter_tb.sv
